// File: rtl/obsd_pkg.sv
// Package for the oriented box signed distance core.
// Holds the widths, register indexes, reset values and pipeline struct.
// No dependencies.
package obsd_pkg;

  localparam int COORD_W  = 16;
  localparam int DIST_W   = 24;
  localparam int LANE_W   = 16;
  localparam int REG_W    = 3 * LANE_W;
  localparam int NUM_REGS = 5;
  localparam int IDX_W    = 3;

  localparam int DIFF_W = ((COORD_W > LANE_W) ? COORD_W : LANE_W) + 1;
  localparam int PROD_W = DIFF_W + LANE_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int RND_SH = 14;
  localparam int LOC_W  = DOT_W - RND_SH;
  localparam int D_W    = LOC_W + 2;
  localparam int SQ_W   = 2 * (D_W - 1);
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int WIDE_W = ((ROOT_W + 2 > D_W) ? ROOT_W + 2 : D_W) + DIST_W;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER  = 3'd0,
    REG_RIGHT   = 3'd1,
    REG_UP      = 3'd2,
    REG_FORWARD = 3'd3,
    REG_HALF    = 3'd4
  } reg_idx_t;

  localparam logic [REG_W-1:0] RST_CENTER  = 48'd0;
  localparam logic [REG_W-1:0] RST_RIGHT   = 48'd3221225472;
  localparam logic [REG_W-1:0] RST_UP      = 48'd16384;
  localparam logic [REG_W-1:0] RST_FORWARD = 48'd70368744177664;
  localparam logic [REG_W-1:0] RST_HALF    = 48'd549764202624;

  // transaction state carried along the square root chain
  typedef struct packed {
    logic                    valid;
    logic                    far;
    logic                    mx_pos;
    logic signed [D_W-1:0]   mx;
    logic [SUM_W-1:0]        rad;
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
  } sq_t;

endpackage

// File: rtl/obsd_front.sv
// Front pipeline: centre subtraction, axis products, rounding, |loc|-h, squares.
// Four register stages; emits the first square root chain word. Uses obsd_pkg.
module obsd_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [obsd_pkg::COORD_W-1:0]    px,
  input  logic signed [obsd_pkg::COORD_W-1:0]    py,
  input  logic signed [obsd_pkg::COORD_W-1:0]    pz,
  input  logic [obsd_pkg::REG_W-1:0]             center,
  input  logic [obsd_pkg::REG_W-1:0]             ax_right,
  input  logic [obsd_pkg::REG_W-1:0]             ax_up,
  input  logic [obsd_pkg::REG_W-1:0]             ax_fwd,
  input  logic [obsd_pkg::REG_W-1:0]             half,
  output obsd_pkg::sq_t                          sq_out
);
  localparam int LW = obsd_pkg::LANE_W;

  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [obsd_pkg::DIFF_W-1:0] diff_r [3];
  logic signed [obsd_pkg::PROD_W-1:0] prod_r [3][3];
  logic signed [obsd_pkg::D_W-1:0]    d_r [3];
  logic                               far_r, mxpos_r;
  logic signed [obsd_pkg::D_W-1:0]    mx_r;
  logic [obsd_pkg::SQ_W-1:0]          sq_r [3];

  logic signed [obsd_pkg::COORD_W-1:0] pt [3];
  logic [obsd_pkg::REG_W-1:0]          axis [3];
  logic signed [obsd_pkg::DOT_W-1:0]   dot [3];
  logic signed [obsd_pkg::DOT_W-1:0]   dot_rnd [3];
  logic signed [obsd_pkg::LOC_W-1:0]   loc [3];
  logic [obsd_pkg::LOC_W:0]            mag [3];
  logic [LW-1:0]                       h [3];
  logic signed [obsd_pkg::D_W-1:0]     d_nxt [3];
  logic                                far_nxt;
  logic signed [obsd_pkg::D_W-1:0]     mx_nxt;
  logic [obsd_pkg::D_W-2:0]            dpos [3];
  logic signed [obsd_pkg::WIDE_W-1:0]  dmax_w;

  assign pt[0] = px;
  assign pt[1] = py;
  assign pt[2] = pz;
  assign axis[0] = ax_right;
  assign axis[1] = ax_up;
  assign axis[2] = ax_fwd;
  assign dmax_w = obsd_pkg::WIDE_W'((64'sd1 <<< (obsd_pkg::DIST_W - 1)) - 64'sd1);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dot[a] = obsd_pkg::DOT_W'(prod_r[a][0]) + obsd_pkg::DOT_W'(prod_r[a][1])
             + obsd_pkg::DOT_W'(prod_r[a][2]);
      dot_rnd[a] = (dot[a] + obsd_pkg::DOT_W'(1 << (obsd_pkg::RND_SH - 1)))
                   >>> obsd_pkg::RND_SH;
      loc[a] = dot_rnd[a][obsd_pkg::LOC_W-1:0];
      mag[a] = loc[a][obsd_pkg::LOC_W-1] ? (~{loc[a][obsd_pkg::LOC_W-1], loc[a]} + 1'b1)
                                         : {1'b0, loc[a]};
      h[a] = half[LW*a +: LW];
      if (h[a] == '0) h[a] = LW'(1);
      d_nxt[a] = $signed({1'b0, mag[a]}) - $signed(obsd_pkg::D_W'({1'b0, h[a]}));
    end
    far_nxt = 1'b0;
    for (int a = 0; a < 3; a++)
      if (obsd_pkg::WIDE_W'(d_r[a]) > dmax_w) far_nxt = 1'b1;
    mx_nxt = d_r[0];
    if (d_r[1] > mx_nxt) mx_nxt = d_r[1];
    if (d_r[2] > mx_nxt) mx_nxt = d_r[2];
    for (int a = 0; a < 3; a++)
      dpos[a] = (d_r[a] > 0) ? d_r[a][obsd_pkg::D_W-2:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        diff_r[i] <= obsd_pkg::DIFF_W'(pt[i])
                   - obsd_pkg::DIFF_W'($signed(center[LW*i +: LW]));
      for (int a = 0; a < 3; a++)
        for (int i = 0; i < 3; i++)
          prod_r[a][i] <= obsd_pkg::PROD_W'(diff_r[i])
                        * obsd_pkg::PROD_W'($signed(axis[a][LW*i +: LW]));
      for (int a = 0; a < 3; a++) d_r[a] <= d_nxt[a];
      far_r   <= far_nxt;
      mx_r    <= mx_nxt;
      mxpos_r <= (mx_nxt > 0);
      for (int a = 0; a < 3; a++) sq_r[a] <= dpos[a] * dpos[a];
    end
  end

  always_comb begin
    sq_out.valid  = v4_r;
    sq_out.far    = far_r;
    sq_out.mx_pos = mxpos_r;
    sq_out.mx     = mx_r;
    sq_out.rad    = obsd_pkg::SUM_W'(sq_r[0]) + obsd_pkg::SUM_W'(sq_r[1])
                  + obsd_pkg::SUM_W'(sq_r[2]);
    sq_out.rem    = '0;
    sq_out.root   = '0;
  end

endmodule

// File: rtl/obsd_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per transaction.
// Registered output, advances on en. Uses obsd_pkg.
module obsd_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  obsd_pkg::sq_t  sin,
  output obsd_pkg::sq_t  sout
);
  obsd_pkg::sq_t sout_r, sout_nxt;
  logic [obsd_pkg::REM_W+1:0] rem2, trial;
  logic                       ge;

  always_comb begin
    rem2  = {sin.rem, sin.rad[obsd_pkg::SUM_W-1 -: 2]};
    trial = {2'b00, sin.root, 2'b01};
    ge    = (rem2 >= trial);
    sout_nxt      = sin;
    sout_nxt.rad  = sin.rad << 2;
    // remainder stays below 2*root+1, so the top bits drop cleanly
    sout_nxt.rem  = ge ? obsd_pkg::REM_W'(rem2 - trial) : obsd_pkg::REM_W'(rem2);
    sout_nxt.root = {sin.root[obsd_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sout_r.valid <= 1'b0;
    else if (en) sout_r <= sout_nxt;
  end

  assign sout = sout_r;

endmodule

// File: rtl/oriented_box_signed_distance_core.sv
// Top level of the oriented box signed distance core.
// Config registers, front pipeline, square root cell chain, output stage.
// Uses obsd_pkg, obsd_front, obsd_sqrt_cell.
//
//   channel | ports                                  | direction
//   input   | in_valid in_stall in_point_x/y/z      | in
//   output  | out_valid out_stall out_signed_distance out_clipped | out
//   config  | cfg_we cfg_index cfg_wdata             | in
//
// One point per cycle while no output stall holds the pipeline. The pipeline is 4 front
// stages + ROOT_W (23) root cells + 1 output stage; the root chain resolves one bit per cell.
// rst_n is synchronous; it clears valid bits and loads register defaults.
// An output stall while out_valid is high freezes the whole pipeline; in_stall follows it.
module oriented_box_signed_distance_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [obsd_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [obsd_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [obsd_pkg::COORD_W-1:0] in_point_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [obsd_pkg::DIST_W-1:0]  out_signed_distance,
  output logic                                out_clipped,
  input  logic                                cfg_we,
  input  logic [obsd_pkg::IDX_W-1:0]          cfg_index,
  input  logic [obsd_pkg::REG_W-1:0]          cfg_wdata
);
  localparam int NC = obsd_pkg::ROOT_W;

  logic [obsd_pkg::REG_W-1:0] center_r, right_r, up_r, fwd_r, half_r;
  logic en;
  obsd_pkg::sq_t chain [NC+1];

  logic                              out_valid_r, clip_r;
  logic signed [obsd_pkg::DIST_W-1:0] dist_r;
  logic [obsd_pkg::ROOT_W:0]          root_rnd;
  logic signed [obsd_pkg::WIDE_W-1:0] raw, dmax_w, dmin_w;
  logic signed [obsd_pkg::DIST_W-1:0] dist_nxt;
  logic                               clip_nxt;

  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= obsd_pkg::RST_CENTER;
      right_r  <= obsd_pkg::RST_RIGHT;
      up_r     <= obsd_pkg::RST_UP;
      fwd_r    <= obsd_pkg::RST_FORWARD;
      half_r   <= obsd_pkg::RST_HALF;
    end else if (cfg_we) begin
      case (cfg_index)
        obsd_pkg::REG_CENTER:  center_r <= cfg_wdata;
        obsd_pkg::REG_RIGHT:   right_r  <= cfg_wdata;
        obsd_pkg::REG_UP:      up_r     <= cfg_wdata;
        obsd_pkg::REG_FORWARD: fwd_r    <= cfg_wdata;
        obsd_pkg::REG_HALF:    half_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  obsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .px       (in_point_x),
    .py       (in_point_y),
    .pz       (in_point_z),
    .center   (center_r),
    .ax_right (right_r),
    .ax_up    (up_r),
    .ax_fwd   (fwd_r),
    .half     (half_r),
    .sq_out   (chain[0])
  );

  for (genvar c = 0; c < NC; c++) begin : g_cell
    obsd_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .sin   (chain[c]),
      .sout  (chain[c+1])
    );
  end

  assign dmax_w = obsd_pkg::WIDE_W'((64'sd1 <<< (obsd_pkg::DIST_W - 1)) - 64'sd1);
  assign dmin_w = -dmax_w - obsd_pkg::WIDE_W'(1);

  always_comb begin
    // round to nearest: bump when remainder exceeds the floor root
    root_rnd = {1'b0, chain[NC].root}
             + ((obsd_pkg::ROOT_W+1)'(chain[NC].rem) > {1'b0, chain[NC].root}
                ? (obsd_pkg::ROOT_W+1)'(1) : '0);
    raw = chain[NC].mx_pos ? obsd_pkg::WIDE_W'($signed({1'b0, root_rnd}))
                           : obsd_pkg::WIDE_W'(chain[NC].mx);
    clip_nxt = 1'b0;
    dist_nxt = raw[obsd_pkg::DIST_W-1:0];
    if (chain[NC].far || raw > dmax_w) begin
      dist_nxt = dmax_w[obsd_pkg::DIST_W-1:0];
      clip_nxt = 1'b1;
    end else if (raw < dmin_w) begin
      dist_nxt = dmin_w[obsd_pkg::DIST_W-1:0];
      clip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= chain[NC].valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_signed_distance = dist_r;
  assign out_clipped         = clip_r;

  a_stall_tracks_out: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not track output stall");

  a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_signed_distance == dmax_w[obsd_pkg::DIST_W-1:0] ||
       out_signed_distance == dmin_w[obsd_pkg::DIST_W-1:0]))
    else $error("clipped result is not a saturation value");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
